// File: rtl/core/bitmap_page_allocator_assert.svh
// Assertion macros used by the page allocator controller (bpa_ctrl).
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bpa_pkg.sv
// Shared types, constants and helpers for the bitmap page allocator.
// No dependencies; used by bpa_ctrl, bpa_dp and bitmap_page_allocator.
package bpa_pkg;

  // Bitmap geometry
  localparam int BLOCKS     = 256;
  localparam int WORD_W     = 32;
  localparam int WORDS      = BLOCKS / WORD_W;
  localparam int WORD_IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int IDX_W      = WORD_IDX_W + BIT_W;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 9;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int PAGE_SHIFT = 12;
  localparam int PIDX_W     = ADDR_W - PAGE_SHIFT;

  // Reset values of the configuration registers
  localparam logic [ADDR_W-1:0] MEM_BASE_RST    = 32'h0010_0000;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 9'd256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // Request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_RESULT
  } bpa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;   // capture request fields, rewind scan
    logic scan_step;  // examine one bitmap word
    logic free_do;    // range-check and clear one bit
    logic out_load;   // move result into output register
  } bpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // current word hit, or no words left in range
  } bpa_sts_t;

  // Index of the lowest set bit; zero when none set
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/bpa_dp.sv
// Datapath of the bitmap page allocator: config registers, used-bit map,
// word scanner with priority encoder, free range check and output register.
// Depends on bpa_pkg.
module bpa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpa_pkg::bpa_cmd_t              cmd,
  output bpa_pkg::bpa_sts_t              sts,
  input  logic                           in_func,
  input  logic [bpa_pkg::ADDR_W-1:0]     in_free_address,
  input  logic                           cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]     cfg_data,
  output logic [bpa_pkg::ADDR_W-1:0]     out_block_address,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status
);

  logic [bpa_pkg::ADDR_W-1:0]     mem_base_r;
  logic [bpa_pkg::CNT_W-1:0]      block_count_r;
  logic [bpa_pkg::WORD_W-1:0]     bitmap_r [bpa_pkg::WORDS];
  logic [bpa_pkg::WORD_IDX_W-1:0] scan_word_r;
  logic                           func_r;
  logic [bpa_pkg::ADDR_W-1:0]     req_addr_r;
  logic [bpa_pkg::IDX_W-1:0]      res_idx_r;
  logic [bpa_pkg::STATUS_W-1:0]   res_status_r;
  logic [bpa_pkg::ADDR_W-1:0]     out_block_address_r;
  logic [bpa_pkg::STATUS_W-1:0]   out_status_r;

  logic [bpa_pkg::CNT_W-1:0]      act_cnt;
  logic [bpa_pkg::WORD_W-1:0]     cur_word;
  logic [bpa_pkg::WORD_W-1:0]     range_mask;
  logic [bpa_pkg::WORD_W-1:0]     cand;
  logic                           hit;
  logic [bpa_pkg::BIT_W-1:0]      hit_bit;
  logic [bpa_pkg::CNT_W:0]        next_base;
  logic                           last_word;
  logic [bpa_pkg::ADDR_W-1:0]     free_diff;
  logic [bpa_pkg::PIDX_W-1:0]     free_pidx;
  logic                           free_ok;
  logic [bpa_pkg::IDX_W-1:0]      free_idx;
  logic [bpa_pkg::ADDR_W-1:0]     res_addr;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_base_r    <= bpa_pkg::MEM_BASE_RST;
      block_count_r <= bpa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpa_pkg::CFG_MEM_BASE:    mem_base_r    <= cfg_data;
        bpa_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_data[bpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Active count is clamped to the bitmap size
  assign act_cnt = (block_count_r > bpa_pkg::CNT_W'(bpa_pkg::BLOCKS)) ?
                   bpa_pkg::CNT_W'(bpa_pkg::BLOCKS) : block_count_r;

  // One word per scan step: free bits below the active count
  always_comb begin
    cur_word = bitmap_r[scan_word_r];
    for (int b = 0; b < bpa_pkg::WORD_W; b++) begin
      range_mask[b] = {1'b0, scan_word_r, bpa_pkg::BIT_W'(b)} < act_cnt;
    end
    cand      = ~cur_word & range_mask;
    hit       = |cand;
    hit_bit   = bpa_pkg::lowest_set(cand);
    next_base = {2'b00, scan_word_r, {bpa_pkg::BIT_W{1'b0}}}
                + (bpa_pkg::CNT_W + 1)'(bpa_pkg::WORD_W);
    last_word = (scan_word_r == bpa_pkg::WORD_IDX_W'(bpa_pkg::WORDS - 1)) ||
                (next_base >= {1'b0, act_cnt});
  end

  assign sts.scan_done = hit || last_word;

  // Free: block index from the address offset, checked against the count
  assign free_diff = req_addr_r - mem_base_r;
  assign free_pidx = free_diff[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
  assign free_ok   = free_pidx < bpa_pkg::PIDX_W'(act_cnt);
  assign free_idx  = free_pidx[bpa_pkg::IDX_W-1:0];

  // Used-bit map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < bpa_pkg::WORDS; w++) bitmap_r[w] <= '0;
    end else if (cmd.scan_step && hit) begin
      bitmap_r[scan_word_r][hit_bit] <= 1'b1;
    end else if (cmd.free_do && free_ok) begin
      bitmap_r[free_idx[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W]]
              [free_idx[bpa_pkg::BIT_W-1:0]] <= 1'b0;
    end
  end

  // Scan word pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_word_r <= '0;
    end else if (cmd.load_req) begin
      scan_word_r <= '0;
    end else if (cmd.scan_step) begin
      scan_word_r <= scan_word_r + bpa_pkg::WORD_IDX_W'(1);
    end
  end

  // Request capture and per-request result
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r     <= in_func;
      req_addr_r <= in_free_address;
    end
    if (cmd.scan_step) begin
      if (hit) begin
        res_idx_r    <= {scan_word_r, hit_bit};
        res_status_r <= bpa_pkg::ST_DONE;
      end else if (last_word) begin
        res_status_r <= bpa_pkg::ST_NONE_FREE;
      end
    end else if (cmd.free_do) begin
      res_status_r <= free_ok ? bpa_pkg::ST_DONE : bpa_pkg::ST_RANGE;
    end
  end

  // Block address only for a successful allocate
  assign res_addr = (func_r == bpa_pkg::FUNC_ALLOC && res_status_r == bpa_pkg::ST_DONE) ?
                    mem_base_r + {bpa_pkg::PIDX_W'(res_idx_r), {bpa_pkg::PAGE_SHIFT{1'b0}}} :
                    '0;

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_block_address_r <= res_addr;
      out_status_r        <= res_status_r;
    end
  end

  assign out_block_address = out_block_address_r;
  assign out_status        = out_status_r;

endmodule

// File: rtl/core/bpa_ctrl.sv
// Controller of the bitmap page allocator: request sequencing and the
// output valid flag. Depends on bpa_pkg and the assertion macro header.
`include "bitmap_page_allocator_assert.svh"

module bpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  output logic               out_valid,
  input  logic               out_ready,
  output bpa_pkg::bpa_cmd_t  cmd,
  input  bpa_pkg::bpa_sts_t  sts
);

  bpa_pkg::bpa_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  assign accept = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == bpa_pkg::FUNC_FREE) ? bpa_pkg::S_FREE : bpa_pkg::S_SCAN;
        end
      end
      bpa_pkg::S_SCAN: begin
        if (sts.scan_done) state_nxt = bpa_pkg::S_RESULT;
      end
      bpa_pkg::S_FREE:   state_nxt = bpa_pkg::S_RESULT;
      bpa_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) state_nxt = bpa_pkg::S_IDLE;
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      bpa_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      bpa_pkg::S_SCAN:   cmd.scan_step = 1'b1;
      bpa_pkg::S_FREE:   cmd.free_do   = 1'b1;
      bpa_pkg::S_RESULT: cmd.out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Output beat pending flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BPA_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_r || out_ready, "result overwrote a pending beat")
  `BPA_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_r, "loaded result not presented")
  `BPA_ASSERT_NEXT(a_accept_moves, accept, state_r != bpa_pkg::S_IDLE, "accepted request not started")
  `BPA_ASSERT_NEXT(a_scan_ends, cmd.scan_step && sts.scan_done, state_r == bpa_pkg::S_RESULT, "scan end missed")

endmodule

// File: rtl/core/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: joins controller and datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
//  channel   direction  handshake              payload
//  in_       input      in_valid / in_ready    in_func, in_free_address
//  out_      output     out_valid / out_ready  out_block_address, out_status
//  cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Allocate: accept, then a scan of the bitmap, one 32-bit word per cycle
// through the priority encoder, up to the first free block, then result.
// Free: accept, range check and clear, result.
// Reset clears the 256-bit map and loads the default config.
// A held output beat stalls only the result step; the next request is
// accepted as soon as the previous result sits in the output register.
module bitmap_page_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [bpa_pkg::ADDR_W-1:0]     in_free_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpa_pkg::ADDR_W-1:0]     out_block_address,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]     cfg_data
);

  bpa_pkg::bpa_cmd_t cmd;
  bpa_pkg::bpa_sts_t sts;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bpa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_free_address   (in_free_address),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_block_address (out_block_address),
    .out_status        (out_status)
  );

endmodule
